>>> sv/homogeneous_vector_alu_assert.svh
// Assertion macros for the homogeneous vector ALU.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef HOMOGENEOUS_VECTOR_ALU_ASSERT_SVH
`define HOMOGENEOUS_VECTOR_ALU_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HVA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("homogeneous_vector_alu: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define HVA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("homogeneous_vector_alu: next-cycle check failed");

`endif

>>> sv/hva_pkg.sv
// Shared types and constants for the homogeneous vector ALU.
// No dependencies.
package hva_pkg;

  localparam int COMP_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CMD_W          = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_SCALE    = 4'd2,
    CMD_HADAMARD = 4'd3,
    CMD_DIV      = 4'd4,
    CMD_NEG      = 4'd5,
    CMD_MAG      = 4'd6,
    CMD_NORM     = 4'd7,
    CMD_DOT      = 4'd8,
    CMD_CROSS    = 4'd9
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic pt;
    logic vec;
  } ctrl_t;

endpackage

>>> sv/hva_front.sv
// Front end: input register, multiplier stage and summing stage.
// Depends on hva_pkg.
module hva_front #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [hva_pkg::CMD_W-1:0]  cmd_i,
  input  logic [3:0][W-1:0]          a_i,
  input  logic [3:0][W-1:0]          b_i,
  input  logic [W-1:0]               s_i,
  output logic                       valid_o,
  output hva_pkg::ctrl_t             ctrl_o,
  output logic [3:0][W-1:0]          r_o,
  output logic [W-1:0]               sc_o,
  output logic [2*W-1:0]             sq_o
);
  import hva_pkg::*;

  localparam int XW = 2*W+2;
  localparam logic signed [XW-1:0] XMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] XMIN = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_FX = {{(W-1){1'b0}}, 1'b1} << F;

  function automatic logic [W-1:0] sat_x(input logic signed [XW-1:0] v);
    logic [W-1:0] res;
    if (v > XMAX) begin
      res = XMAX[W-1:0];
    end else if (v < XMIN) begin
      res = XMIN[W-1:0];
    end else begin
      res = v[W-1:0];
    end
    return res;
  endfunction

  // Input register.
  logic             v0_q;
  cmd_e             cmd0_q;
  logic [3:0][W-1:0] a0_q, b0_q;
  logic [W-1:0]     s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd0_q <= cmd_e'(cmd_i);
      a0_q   <= a_i;
      b0_q   <= b_i;
      s0_q   <= s_i;
    end
  end

  // Multiplier stage.
  logic signed [W-1:0]   opa [6];
  logic signed [W-1:0]   opb [6];
  logic signed [2*W-1:0] prod_d [6];
  logic [3:0][W-1:0]     lin_d;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      opa[k] = '0;
      opb[k] = '0;
    end
    lin_d = '0;
    case (cmd0_q)
      CMD_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          opa[i] = a0_q[i];
          opb[i] = s0_q;
        end
      end
      CMD_HADAMARD, CMD_DOT: begin
        for (int i = 0; i < 4; i++) begin
          opa[i] = a0_q[i];
          opb[i] = b0_q[i];
        end
      end
      CMD_MAG, CMD_NORM: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = a0_q[i];
          opb[i] = a0_q[i];
        end
        if (cmd0_q == CMD_NORM) begin
          lin_d = a0_q;
        end
      end
      CMD_CROSS: begin
        opa[0] = a0_q[1]; opb[0] = b0_q[2];
        opa[1] = a0_q[2]; opb[1] = b0_q[1];
        opa[2] = a0_q[2]; opb[2] = b0_q[0];
        opa[3] = a0_q[0]; opb[3] = b0_q[2];
        opa[4] = a0_q[0]; opb[4] = b0_q[1];
        opa[5] = a0_q[1]; opb[5] = b0_q[0];
      end
      CMD_ADD: begin
        for (int i = 0; i < 4; i++) begin
          lin_d[i] = sat_x(XW'($signed(a0_q[i])) + XW'($signed(b0_q[i])));
        end
      end
      CMD_SUB: begin
        for (int i = 0; i < 4; i++) begin
          lin_d[i] = sat_x(XW'($signed(a0_q[i])) - XW'($signed(b0_q[i])));
        end
      end
      CMD_NEG: begin
        for (int i = 0; i < 4; i++) begin
          lin_d[i] = sat_x(-XW'($signed(a0_q[i])));
        end
      end
      CMD_DIV: begin
        lin_d = a0_q;
      end
      default: begin
        lin_d = '0;
      end
    endcase
    for (int k = 0; k < 6; k++) begin
      prod_d[k] = opa[k] * opb[k];
    end
  end

  logic                  v1_q;
  cmd_e                  cmd1_q;
  logic                  pt1_q, vec1_q;
  logic signed [2*W-1:0] prod_q [6];
  logic [3:0][W-1:0]     lin_q;
  logic [W-1:0]          s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd1_q <= cmd0_q;
      pt1_q  <= (a0_q[3] == ONE_FX);
      vec1_q <= (a0_q[3] == '0);
      for (int k = 0; k < 6; k++) begin
        prod_q[k] <= prod_d[k];
      end
      lin_q  <= lin_d;
      s1_q   <= s0_q;
    end
  end

  // Summing stage: exact sums, floored by the fraction width, then saturated; the sum of squares is kept unscaled.
  logic signed [XW-1:0] ext [6];
  logic signed [XW-1:0] sq_sum;
  logic [3:0][W-1:0]    r_d;
  logic [W-1:0]         sc_d;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ext[k] = XW'(prod_q[k]);
    end
    sq_sum = ext[0] + ext[1] + ext[2];
    r_d    = '0;
    sc_d   = '0;
    case (cmd1_q)
      CMD_ADD, CMD_SUB, CMD_NEG, CMD_NORM: begin
        r_d = lin_q;
      end
      CMD_DIV: begin
        r_d  = lin_q;
        sc_d = s1_q;
      end
      CMD_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          r_d[i] = sat_x(ext[i] >>> F);
        end
      end
      CMD_HADAMARD: begin
        for (int i = 0; i < 3; i++) begin
          r_d[i] = sat_x(ext[i] >>> F);
        end
      end
      CMD_DOT: begin
        sc_d = sat_x((ext[0] + ext[1] + ext[2] + ext[3]) >>> F);
      end
      CMD_CROSS: begin
        r_d[0] = sat_x((ext[0] - ext[1]) >>> F);
        r_d[1] = sat_x((ext[2] - ext[3]) >>> F);
        r_d[2] = sat_x((ext[4] - ext[5]) >>> F);
      end
      default: begin
        r_d = '0;
      end
    endcase
  end

  logic              v2_q;
  ctrl_t             ctrl2_q;
  logic [3:0][W-1:0] r2_q;
  logic [W-1:0]      sc2_q;
  logic [2*W-1:0]    sq2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl2_q.cmd <= cmd1_q;
      ctrl2_q.pt  <= pt1_q;
      ctrl2_q.vec <= vec1_q;
      r2_q        <= r_d;
      sc2_q       <= sc_d;
      sq2_q       <= sq_sum[2*W-1:0];
    end
  end

  assign valid_o = v2_q;
  assign ctrl_o  = ctrl2_q;
  assign r_o     = r2_q;
  assign sc_o    = sc2_q;
  assign sq_o    = sq2_q;

endmodule

>>> sv/hva_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a side payload.
// Depends on hva_pkg only through its parent.
module hva_isqrt #(
  parameter int W      = 32,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*W-1:0]    rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [W-1:0]      root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_s    [W+1];
  logic [W-1:0]      rem_s  [W+1];
  logic [W-1:0]      root_s [W+1];
  logic [2*W-1:0]    rad_s  [W+1];
  logic [SIDE_W-1:0] side_s [W+1];

  logic              v_q    [W];
  logic [W-1:0]      rem_q  [W];
  logic [W-1:0]      root_q [W];
  logic [2*W-1:0]    rad_q  [W];
  logic [SIDE_W-1:0] side_q [W];

  assign v_s[0]    = valid_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = rad_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W+1:0] cur, trial, diff;
    logic         ge;

    assign cur   = {rem_s[k], rad_s[k][2*W-1:2*W-2]};
    assign trial = {root_s[k], 2'b01};
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[W-1:0] : cur[W-1:0];
        root_q[k] <= {root_s[k][W-2:0], ge};
        rad_q[k]  <= rad_s[k] << 2;
        side_q[k] <= side_s[k];
      end
    end

    assign v_s[k+1]    = v_q[k];
    assign rem_s[k+1]  = rem_q[k];
    assign root_s[k+1] = root_q[k];
    assign rad_s[k+1]  = rad_q[k];
    assign side_s[k+1] = side_q[k];
  end

  assign valid_o = v_s[W];
  assign root_o  = root_s[W];
  assign side_o  = side_s[W];

endmodule

>>> sv/hva_div.sv
// Pipelined restoring divider, four lanes sharing one divisor, one quotient
// bit per stage, with a side payload. Depends on hva_pkg only through its parent.
module hva_div #(
  parameter int W      = 32,
  parameter int N      = 48,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [3:0][N-1:0] dvd_i,
  input  logic [W-1:0]      dvs_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [3:0][N-1:0] quot_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_s    [N+1];
  logic [W-1:0]      dvs_s  [N+1];
  logic [SIDE_W-1:0] side_s [N+1];
  logic [W-1:0]      rem_s  [N+1][4];
  logic [N-1:0]      dq_s   [N+1][4];

  logic              v_q    [N];
  logic [W-1:0]      dvs_q  [N];
  logic [SIDE_W-1:0] side_q [N];
  logic [W-1:0]      rem_q  [N][4];
  logic [N-1:0]      dq_q   [N][4];

  assign v_s[0]    = valid_i;
  assign dvs_s[0]  = dvs_i;
  assign side_s[0] = side_i;

  for (genvar l = 0; l < 4; l++) begin : g_in
    assign rem_s[0][l] = '0;
    assign dq_s[0][l]  = dvd_i[l];
    assign quot_o[l]   = dq_s[N][l];
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [W:0] cur, diff;
      logic       ge;

      assign cur  = {rem_s[k][l], dq_s[k][l][N-1]};
      assign diff = cur - {1'b0, dvs_s[k]};
      assign ge   = (cur >= {1'b0, dvs_s[k]});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge ? diff[W-1:0] : cur[W-1:0];
          dq_q[k][l]  <= {dq_s[k][l][N-2:0], ge};
        end
      end

      assign rem_s[k+1][l] = rem_q[k][l];
      assign dq_s[k+1][l]  = dq_q[k][l];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvs_q[k]  <= dvs_s[k];
        side_q[k] <= side_s[k];
      end
    end

    assign v_s[k+1]    = v_q[k];
    assign dvs_s[k+1]  = dvs_q[k];
    assign side_s[k+1] = side_q[k];
  end

  assign valid_o = v_s[N];
  assign side_o  = side_s[N];

endmodule

>>> sv/homogeneous_vector_alu.sv
// Stages from input beat to output beat (default format Q16.16): three front
// stages, one per root bit, one prep stage, one per quotient bit, one output
// register. Throughput: one beat per cycle; the whole pipeline halts while
// the output register holds a beat that is not taken. Reset clears the valid
// bits only. Top level of the homogeneous vector ALU; depends on hva_pkg and
// its submodules.
module homogeneous_vector_alu #(
  parameter int COMP_WIDTH = hva_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = hva_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [hva_pkg::CMD_W-1:0] command_i,
  input  logic [COMP_WIDTH-1:0]     a_x_i,
  input  logic [COMP_WIDTH-1:0]     a_y_i,
  input  logic [COMP_WIDTH-1:0]     a_z_i,
  input  logic [COMP_WIDTH-1:0]     a_w_i,
  input  logic [COMP_WIDTH-1:0]     b_x_i,
  input  logic [COMP_WIDTH-1:0]     b_y_i,
  input  logic [COMP_WIDTH-1:0]     b_z_i,
  input  logic [COMP_WIDTH-1:0]     b_w_i,
  input  logic [COMP_WIDTH-1:0]     scalar_in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [COMP_WIDTH-1:0]     r_x_o,
  output logic [COMP_WIDTH-1:0]     r_y_o,
  output logic [COMP_WIDTH-1:0]     r_z_o,
  output logic [COMP_WIDTH-1:0]     r_w_o,
  output logic [COMP_WIDTH-1:0]     scalar_out_o,
  output logic                      div_error_o,
  output logic                      a_is_point_o,
  output logic                      a_is_vector_o
);
  import hva_pkg::*;

  localparam int W         = COMP_WIDTH;
  localparam int F         = FRAC_BITS;
  localparam int N         = W + F;
  localparam int SQ_SIDE_W = $bits(ctrl_t) + 5*W;
  localparam int DV_SIDE_W = $bits(ctrl_t) + 5 + 5*W;
  localparam logic [W-1:0] VMAX     = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN     = {1'b1, {(W-1){1'b0}}};
  localparam logic [N-1:0] QMAX     = {{(N-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [N-1:0] QMIN_MAG = QMAX + N'(1);

  logic en;
  logic out_v_q;

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  // Front end.
  logic              f_v;
  ctrl_t             f_ctrl;
  logic [3:0][W-1:0] f_r;
  logic [W-1:0]      f_sc;
  logic [2*W-1:0]    f_sq;

  hva_front #(
    .W (W),
    .F (F)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .cmd_i   (command_i),
    .a_i     ({a_w_i, a_z_i, a_y_i, a_x_i}),
    .b_i     ({b_w_i, b_z_i, b_y_i, b_x_i}),
    .s_i     (scalar_in_i),
    .valid_o (f_v),
    .ctrl_o  (f_ctrl),
    .r_o     (f_r),
    .sc_o    (f_sc),
    .sq_o    (f_sq)
  );

  // Magnitude.
  logic                 s_v;
  logic [W-1:0]         root;
  logic [SQ_SIDE_W-1:0] sq_side;
  ctrl_t                s_ctrl;
  logic [3:0][W-1:0]    s_r;
  logic [W-1:0]         s_sc;

  hva_isqrt #(
    .W      (W),
    .SIDE_W (SQ_SIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_v),
    .rad_i   (f_sq),
    .side_i  ({f_ctrl, f_r, f_sc}),
    .valid_o (s_v),
    .root_o  (root),
    .side_o  (sq_side)
  );

  assign {s_ctrl, s_r, s_sc} = sq_side;

  // Divider operand preparation.
  logic              is_div_s, is_norm_s, s_neg, err_d;
  logic [W-1:0]      s_mag, dvs_d, sc_d;
  logic [W-1:0]      amag [4];
  logic [3:0][N-1:0] dvd_d;
  logic [3:0]        neg_d;

  always_comb begin
    is_div_s  = (s_ctrl.cmd == CMD_DIV);
    is_norm_s = (s_ctrl.cmd == CMD_NORM);
    s_neg     = s_sc[W-1];
    s_mag     = s_neg ? (~s_sc + W'(1)) : s_sc;
    dvs_d     = is_div_s ? s_mag : root;
    err_d     = (is_div_s && (s_sc == '0)) || (is_norm_s && (root == '0));
    for (int l = 0; l < 4; l++) begin
      amag[l]  = s_r[l][W-1] ? (~s_r[l] + W'(1)) : s_r[l];
      dvd_d[l] = {amag[l], {F{1'b0}}};
      neg_d[l] = s_r[l][W-1] ^ (is_div_s & s_neg);
    end
    case (s_ctrl.cmd)
      CMD_MAG, CMD_NORM: sc_d = root[W-1] ? VMAX : root;
      CMD_DOT:           sc_d = s_sc;
      default:           sc_d = '0;
    endcase
  end

  logic              p_v_q;
  ctrl_t             p_ctrl_q;
  logic              p_err_q;
  logic [3:0]        p_neg_q;
  logic [3:0][W-1:0] p_r_q;
  logic [W-1:0]      p_sc_q;
  logic [3:0][N-1:0] p_dvd_q;
  logic [W-1:0]      p_dvs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= s_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ctrl_q <= s_ctrl;
      p_err_q  <= err_d;
      p_neg_q  <= neg_d;
      p_r_q    <= s_r;
      p_sc_q   <= sc_d;
      p_dvd_q  <= dvd_d;
      p_dvs_q  <= dvs_d;
    end
  end

  // Division.
  logic                 d_v;
  logic [3:0][N-1:0]    quot;
  logic [DV_SIDE_W-1:0] dv_side;
  ctrl_t                d_ctrl;
  logic                 d_err;
  logic [3:0]           d_neg;
  logic [3:0][W-1:0]    d_r;
  logic [W-1:0]         d_sc;

  hva_div #(
    .W      (W),
    .N      (N),
    .SIDE_W (DV_SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_v_q),
    .dvd_i   (p_dvd_q),
    .dvs_i   (p_dvs_q),
    .side_i  ({p_ctrl_q, p_err_q, p_neg_q, p_r_q, p_sc_q}),
    .valid_o (d_v),
    .quot_o  (quot),
    .side_o  (dv_side)
  );

  assign {d_ctrl, d_err, d_neg, d_r, d_sc} = dv_side;

  // Sign, saturation and result selection.
  logic              is_dv;
  logic [W-1:0]      q_sat [4];
  logic [3:0][W-1:0] r_fin;

  always_comb begin
    is_dv = (d_ctrl.cmd == CMD_DIV) || (d_ctrl.cmd == CMD_NORM);
    for (int l = 0; l < 4; l++) begin
      if (d_neg[l]) begin
        q_sat[l] = (quot[l] > QMIN_MAG) ? VMIN : (~quot[l][W-1:0] + W'(1));
      end else begin
        q_sat[l] = (quot[l] > QMAX) ? VMAX : quot[l][W-1:0];
      end
      if (is_dv) begin
        r_fin[l] = d_err ? '0 : q_sat[l];
      end else begin
        r_fin[l] = d_r[l];
      end
    end
  end

  // Output register.
  logic [3:0][W-1:0] r_q;
  logic [W-1:0]      sc_q;
  logic              err_q, pt_q, vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q   <= r_fin;
      sc_q  <= d_sc;
      err_q <= d_err;
      pt_q  <= d_ctrl.pt;
      vec_q <= d_ctrl.vec;
    end
  end

  assign out_valid_o   = out_v_q;
  assign r_x_o         = r_q[0];
  assign r_y_o         = r_q[1];
  assign r_z_o         = r_q[2];
  assign r_w_o         = r_q[3];
  assign scalar_out_o  = sc_q;
  assign div_error_o   = err_q;
  assign a_is_point_o  = pt_q;
  assign a_is_vector_o = vec_q;

`include "homogeneous_vector_alu_assert.svh"

  `HVA_ASSERT_IMP(a_err_zero_result, out_valid_o && div_error_o,
                  r_x_o == '0 && r_y_o == '0 && r_z_o == '0 && r_w_o == '0)
  `HVA_ASSERT_IMP(a_flags_exclusive, out_valid_o, !(a_is_point_o && a_is_vector_o))
  `HVA_ASSERT_IMP(a_stall_blocks_input, out_valid_o && !out_ready_i, !in_ready_o)
  `HVA_ASSERT_NXT(a_stall_holds_prep, p_v_q && !en, p_v_q)

endmodule
